// ===== rtl/core/pebp_pkg.sv =====
// Shared types and constants of the Pauli error backward propagator.
package pebp_pkg;

  // Field widths of the input and result words
  localparam int CMD_W       = 3;
  localparam int QUBIT_W     = 5;
  localparam int NOISE_IDX_W = 10;
  localparam int FLIPS_W     = 64;

  // Counter and configuration widths
  localparam int MEAS_CNT_W  = 7;
  localparam int NOISE_CNT_W = 11;
  localparam int MEAS_IDX_W  = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 11;

  // Stream word widths, padded to whole bytes
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 208;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // Gate commands
  typedef enum logic [CMD_W-1:0] {
    CMD_START    = 3'd0,
    CMD_DEPOL    = 3'd1,
    CMD_MEASURE  = 3'd2,
    CMD_RESET    = 3'd3,
    CMD_CNOT     = 3'd4,
    CMD_HADAMARD = 3'd5
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEAS_COUNT  = 1'b0,
    REG_NOISE_COUNT = 1'b1
  } cfg_reg_e;

  // Classified operation handed from front to back
  typedef struct packed {
    cmd_e                   kind;
    logic [QUBIT_W-1:0]     qubit_a;
    logic [QUBIT_W-1:0]     qubit_b;
    logic [MEAS_IDX_W-1:0]  meas_idx;
    logic [NOISE_IDX_W-1:0] noise_idx;
  } op_t;

endpackage

// ===== rtl/core/pebp_front.sv =====
// Front end: accepts gate words, drops no-op gates, runs the counters and config registers.
module pebp_front #(
  parameter int NUM_QUBITS = 32,
  parameter int MAX_MEAS   = 64,
  parameter int MAX_NOISE  = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pebp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pebp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [pebp_pkg::CMD_W-1:0]          cmd_i,
  input  logic [pebp_pkg::QUBIT_W-1:0]        qubit_a_i,
  input  logic [pebp_pkg::QUBIT_W-1:0]        qubit_b_i,
  input  logic                                q_full_i,
  output logic                                push_o,
  output pebp_pkg::op_t                       op_o
);
  import pebp_pkg::*;

  localparam int NQ = (NUM_QUBITS < (2 ** QUBIT_W)) ? NUM_QUBITS : (2 ** QUBIT_W);
  localparam logic [QUBIT_W:0] NQ_LIM = (QUBIT_W + 1)'(NQ);
  localparam int NOISE_RST = (MAX_NOISE < 1024) ? MAX_NOISE : 1024;

  logic [MEAS_CNT_W-1:0]  meas_count_q, meas_count_d;
  logic [NOISE_CNT_W-1:0] noise_count_q, noise_count_d;
  logic [MEAS_CNT_W-1:0]  meas_cnt_q, meas_cnt_d, meas_dec;
  logic [NOISE_CNT_W-1:0] noise_cnt_q, noise_cnt_d, noise_dec;
  logic [MEAS_CNT_W-1:0]  meas_wr;
  logic [NOISE_CNT_W-1:0] noise_wr;
  logic qa_ok, qb_ok, keep, accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign qa_ok      = {1'b0, qubit_a_i} < NQ_LIM;
  assign qb_ok      = ({1'b0, qubit_b_i} < NQ_LIM) && (qubit_b_i != qubit_a_i);
  assign meas_dec   = meas_cnt_q - MEAS_CNT_W'(1);
  assign noise_dec  = noise_cnt_q - NOISE_CNT_W'(1);

  // Saturate written counts to the sizing limits
  assign meas_wr  = (int'(cfg_wdata_i[MEAS_CNT_W-1:0]) > MAX_MEAS) ?
                    MEAS_CNT_W'(MAX_MEAS) : cfg_wdata_i[MEAS_CNT_W-1:0];
  assign noise_wr = (int'(cfg_wdata_i[NOISE_CNT_W-1:0]) > MAX_NOISE) ?
                    NOISE_CNT_W'(MAX_NOISE) : cfg_wdata_i[NOISE_CNT_W-1:0];

  always_comb begin
    meas_count_d  = meas_count_q;
    noise_count_d = noise_count_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MEAS_COUNT:  meas_count_d  = meas_wr;
        REG_NOISE_COUNT: noise_count_d = noise_wr;
        default: ;
      endcase
    end
  end

  always_comb begin
    keep              = 1'b0;
    meas_cnt_d        = meas_cnt_q;
    noise_cnt_d       = noise_cnt_q;
    op_o.kind         = CMD_START;
    op_o.qubit_a      = qubit_a_i;
    op_o.qubit_b      = qubit_b_i;
    op_o.meas_idx     = meas_dec[MEAS_IDX_W-1:0];
    op_o.noise_idx    = noise_dec[NOISE_IDX_W-1:0];
    if (accept) begin
      case (cmd_i)
        CMD_START: begin
          keep        = 1'b1;
          meas_cnt_d  = meas_count_q;
          noise_cnt_d = noise_count_q;
        end
        CMD_DEPOL: begin
          if (qa_ok && (noise_cnt_q != '0)) begin
            keep        = 1'b1;
            op_o.kind   = CMD_DEPOL;
            noise_cnt_d = noise_dec;
          end
        end
        CMD_MEASURE: begin
          if (qa_ok && (meas_cnt_q != '0)) begin
            keep       = 1'b1;
            op_o.kind  = CMD_MEASURE;
            meas_cnt_d = meas_dec;
          end
        end
        CMD_RESET: begin
          keep      = qa_ok;
          op_o.kind = CMD_RESET;
        end
        CMD_CNOT: begin
          keep      = qa_ok && qb_ok;
          op_o.kind = CMD_CNOT;
        end
        CMD_HADAMARD: begin
          keep      = qa_ok;
          op_o.kind = CMD_HADAMARD;
        end
        default: ;
      endcase
    end
  end

  assign push_o = keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meas_count_q  <= MEAS_CNT_W'(MAX_MEAS);
      noise_count_q <= NOISE_CNT_W'(NOISE_RST);
      meas_cnt_q    <= MEAS_CNT_W'(MAX_MEAS);
      noise_cnt_q   <= NOISE_CNT_W'(NOISE_RST);
    end else begin
      meas_count_q  <= meas_count_d;
      noise_count_q <= noise_count_d;
      meas_cnt_q    <= meas_cnt_d;
      noise_cnt_q   <= noise_cnt_d;
    end
  end

endmodule

// ===== rtl/core/pebp_fifo.sv =====
// Short operation queue between the front and the back.
module pebp_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pebp_pkg::op_t push_op_i,
  output logic          full_o,
  output logic          valid_o,
  output pebp_pkg::op_t head_o,
  input  logic          pop_i
);
  import pebp_pkg::*;

  op_t               slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign full_o  = count_q == (QPTR_W + 1)'(QDEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (QPTR_W + 1)'(1);
        2'b01:   count_q <= count_q - (QPTR_W + 1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== rtl/core/pebp_back.sv =====
// Back end: row memories, gate execution with forwarding, and the result register.
module pebp_back #(
  parameter int NUM_QUBITS = 32,
  parameter int MAX_MEAS   = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  input  pebp_pkg::op_t                       q_op_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [pebp_pkg::NOISE_IDX_W-1:0]    out_noise_idx_o,
  output logic [pebp_pkg::FLIPS_W-1:0]        out_x_o,
  output logic [pebp_pkg::FLIPS_W-1:0]        out_y_o,
  output logic [pebp_pkg::FLIPS_W-1:0]        out_z_o
);
  import pebp_pkg::*;

  localparam int NQ = (NUM_QUBITS < (2 ** QUBIT_W)) ? NUM_QUBITS : (2 ** QUBIT_W);
  localparam int QW = $clog2(NQ);
  localparam int RW = MAX_MEAS;

  // Y rows are always X ^ Z, so only X and Z are stored
  logic [RW-1:0] x_mem [NQ];
  logic [RW-1:0] z_mem [NQ];
  logic [NQ-1:0] x_vld_q, z_vld_q;

  logic [QW-1:0] ra, rb, a2, b2;
  logic          s2_vld_q;
  op_t           s2_op_q;
  logic [RW-1:0] xa_q, xb_q, za_q, zb_q;
  logic [RW-1:0] xa, xb, za, zb;

  // Last write, for the operation read in the same cycle
  logic          fx_we_q, fz_we_q, fclr_q;
  logic [QW-1:0] fx_addr_q, fz_addr_q;
  logic [RW-1:0] fx_data_q, fz_data_q;

  logic          x_we, z_we, clr, emit, retire, advance;
  logic [QW-1:0] x_addr, z_addr;
  logic [RW-1:0] x_wdata, z_wdata;

  logic                   out_vld_q;
  logic [NOISE_IDX_W-1:0] out_idx_q;
  logic [FLIPS_W-1:0]     out_x_q, out_y_q, out_z_q;

  assign ra = q_op_i.qubit_a[QW-1:0];
  assign rb = (q_op_i.kind == CMD_CNOT) ? q_op_i.qubit_b[QW-1:0] : ra;
  assign a2 = s2_op_q.qubit_a[QW-1:0];
  assign b2 = s2_op_q.qubit_b[QW-1:0];

  always_comb begin
    xa = fclr_q ? '0 : (fx_we_q && (fx_addr_q == a2)) ? fx_data_q : xa_q;
    xb = fclr_q ? '0 : (fx_we_q && (fx_addr_q == b2)) ? fx_data_q : xb_q;
    za = fclr_q ? '0 : (fz_we_q && (fz_addr_q == a2)) ? fz_data_q : za_q;
    zb = fclr_q ? '0 : (fz_we_q && (fz_addr_q == b2)) ? fz_data_q : zb_q;
  end

  always_comb begin
    x_we    = 1'b0;
    z_we    = 1'b0;
    clr     = 1'b0;
    emit    = 1'b0;
    x_addr  = a2;
    z_addr  = a2;
    x_wdata = xa;
    z_wdata = za;
    if (s2_vld_q) begin
      case (s2_op_q.kind)
        CMD_START: clr = 1'b1;
        CMD_DEPOL: emit = 1'b1;
        CMD_MEASURE: begin
          x_we    = 1'b1;
          x_wdata = xa | (RW'(1) << s2_op_q.meas_idx);
        end
        CMD_RESET: begin
          x_we    = 1'b1;
          z_we    = 1'b1;
          x_wdata = '0;
          z_wdata = '0;
        end
        CMD_CNOT: begin
          x_we    = 1'b1;
          z_we    = 1'b1;
          x_wdata = xa ^ xb;
          z_addr  = b2;
          z_wdata = zb ^ za;
        end
        CMD_HADAMARD: begin
          x_we    = 1'b1;
          z_we    = 1'b1;
          x_wdata = za;
          z_wdata = xa;
        end
        default: ;
      endcase
    end
  end

  // Hold a result operation while the output word is still waiting
  assign retire  = !emit || !out_vld_q || out_ready_i;
  assign advance = !s2_vld_q || retire;
  assign q_pop_o = advance && q_valid_i;

  always_ff @(posedge clk_i) begin
    if (x_we) begin
      x_mem[x_addr] <= x_wdata;
    end
    if (z_we) begin
      z_mem[z_addr] <= z_wdata;
    end
    if (q_pop_o) begin
      s2_op_q <= q_op_i;
      xa_q    <= x_vld_q[ra] ? x_mem[ra] : '0;
      xb_q    <= x_vld_q[rb] ? x_mem[rb] : '0;
      za_q    <= z_vld_q[ra] ? z_mem[ra] : '0;
      zb_q    <= z_vld_q[rb] ? z_mem[rb] : '0;
    end
    if (advance) begin
      fx_addr_q <= x_addr;
      fx_data_q <= x_wdata;
      fz_addr_q <= z_addr;
      fz_data_q <= z_wdata;
    end
    if (emit && retire) begin
      out_idx_q <= s2_op_q.noise_idx;
      out_x_q   <= FLIPS_W'(xa);
      out_y_q   <= FLIPS_W'(xa ^ za);
      out_z_q   <= FLIPS_W'(za);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_vld_q   <= '0;
      z_vld_q   <= '0;
      s2_vld_q  <= 1'b0;
      fx_we_q   <= 1'b0;
      fz_we_q   <= 1'b0;
      fclr_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (clr) begin
        x_vld_q <= '0;
        z_vld_q <= '0;
      end else begin
        if (x_we) begin
          x_vld_q[x_addr] <= 1'b1;
        end
        if (z_we) begin
          z_vld_q[z_addr] <= 1'b1;
        end
      end
      if (advance) begin
        s2_vld_q <= q_valid_i;
        fx_we_q  <= x_we;
        fz_we_q  <= z_we;
        fclr_q   <= clr;
      end
      if (emit && retire) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_vld_q;
  assign out_noise_idx_o = out_idx_q;
  assign out_x_o         = out_x_q;
  assign out_y_o         = out_y_q;
  assign out_z_o         = out_z_q;

endmodule

// ===== rtl/core/pauli_error_backward_propagator.sv =====
// Top level of the Pauli error backward propagator.
//
// Feed the gates of a Clifford circuit in reverse order on the slave stream, one
// word per gate. For each qubit the block tracks which measurements an X, Y or
// Z error at the current point would flip. Every depolarize word that is not
// dropped yields one word on the master stream: the noise index and the three
// flip rows of its qubit. All other gates only update the rows.
// Throughput: one gate word per cycle while the master stream does not stall,
// independent of the gate mix. A depolarize word passes the queue entry, the row
// read stage and the output register on its way to the master side.
// A four-word queue parts the front from the row engine; when the receiver
// stalls, the output register holds, the engine stops at the next depolarize,
// the queue fills and s_axis_tready drops.
// Reset clears all rows and loads both counts and counters with their defaults;
// a start word clears the rows and reloads the counters from the counts.
// Write the configuration only while the block is idle.
module pauli_error_backward_propagator #(
  parameter int NUM_QUBITS = 32,
  parameter int MAX_MEAS   = 64,
  parameter int MAX_NOISE  = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [pebp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pebp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // Gate stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // command [2:0], qubit_a [7:3], qubit_b [12:8], zero [15:13]
  input  logic [pebp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Noise report stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // noise_index [9:0], x_flips [73:10], y_flips [137:74], z_flips [201:138],
  // zero [207:202]
  output logic [pebp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import pebp_pkg::*;

  localparam int PAD_W = OUT_TDATA_W - NOISE_IDX_W - 3 * FLIPS_W;

  logic                   q_full, q_push, q_valid, q_pop;
  op_t                    push_op, head_op;
  logic [NOISE_IDX_W-1:0] noise_idx;
  logic [FLIPS_W-1:0]     x_flips, y_flips, z_flips;

  // Classify incoming words and run the counters
  pebp_front #(
    .NUM_QUBITS (NUM_QUBITS),
    .MAX_MEAS   (MAX_MEAS),
    .MAX_NOISE  (MAX_NOISE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (s_axis_tdata[CMD_W-1:0]),
    .qubit_a_i   (s_axis_tdata[CMD_W+QUBIT_W-1:CMD_W]),
    .qubit_b_i   (s_axis_tdata[CMD_W+2*QUBIT_W-1:CMD_W+QUBIT_W]),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .op_o        (push_op)
  );

  // Decouple the front from the row engine
  pebp_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .valid_o   (q_valid),
    .head_o    (head_op),
    .pop_i     (q_pop)
  );

  // Execute row updates and emit noise reports
  pebp_back #(
    .NUM_QUBITS (NUM_QUBITS),
    .MAX_MEAS   (MAX_MEAS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_op_i          (head_op),
    .q_pop_o         (q_pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_noise_idx_o (noise_idx),
    .out_x_o         (x_flips),
    .out_y_o         (y_flips),
    .out_z_o         (z_flips)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, z_flips, y_flips, x_flips, noise_idx};

endmodule
